@@ src/bmp565_pkg.sv @@
// Shared types and constants for the BMP 24-bit to RGB565 stream decoder.
package bmp565_pkg;

  localparam int unsigned HEADER_BYTES = 34;
  localparam logic [15:0] BMP_MAGIC = 16'h4D42;
  localparam logic [15:0] BMP_PLANES = 16'd1;
  localparam logic [15:0] BMP_BPP = 16'd24;
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] pixel_color;
    logic [15:0] pixel_column;
    logic [15:0] pixel_row;
    logic        last_pixel;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [15:0] column;
    logic [15:0] file_row;
    logic [15:0] height;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ src/bmp24_to_rgb565_stream_top.sv @@
// Top level of the BMP 24-bit to RGB565 stream decoder.
// Path: an accepted byte's command is written into a queue slot, then loaded into the output register.
// Throughput: one byte per cycle; the parser takes a byte whenever the two-entry
// command queue has room, and the queue drains into the output register.
// Reset is synchronous and active low; it returns the parser to the header phase
// and empties the queue and the output register.
module bmp24_to_rgb565_stream_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  bmp565_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bmp565_pkg::out_item_t out_data
);
  import bmp565_pkg::*;

  logic      in_acc;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      head;
  q_status_t q_status;

  assign in_stall = q_status.full;
  assign in_acc = in_valid && !in_stall;

  bmp565_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_acc   (in_acc),
    .in_data  (in_data),
    .push     (push),
    .push_cmd (push_cmd)
  );

  bmp565_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  bmp565_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ src/bmp565_front.sv @@
// Front end: parses the header and turns the bytes into accept, reject and pixel commands.
module bmp565_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_acc,
  input  bmp565_pkg::in_item_t in_data,
  output logic                 push,
  output bmp565_pkg::cmd_t     push_cmd
);
  import bmp565_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_HEADER_BAD,
    PH_SKIP,
    PH_PIXEL,
    PH_PAD,
    PH_DONE
  } phase_t;

  phase_t      phase_r, phase_nxt, cur_phase;
  logic [31:0] pos_r, pos_nxt, cur_pos, pos_inc;
  logic [31:0] acc_r, acc_nxt, cur_acc, acc_new;
  logic [31:0] offset_r, offset_nxt;
  logic [15:0] width_r, width_nxt;
  logic [15:0] height_r, height_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] frow_r, frow_nxt;
  logic [1:0]  tri_r, tri_nxt;
  logic [7:0]  blue_r, blue_nxt;
  logic [7:0]  green_r, green_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic [15:0] hi16;
  logic        last_col, last_row;
  logic [7:0]  b;

  always_comb begin
    b = in_data.byte_value;
    cur_phase = in_data.first_byte ? PH_HEADER : phase_r;
    cur_pos = in_data.first_byte ? 32'd0 : pos_r;
    cur_acc = in_data.first_byte ? 32'd0 : acc_r;
    acc_new = {b, cur_acc[31:8]};
    hi16 = acc_new[31:16];
    pos_inc = (cur_pos == 32'hFFFF_FFFF) ? cur_pos : cur_pos + 32'd1;
    last_col = ({1'b0, col_r} + 17'd1) >= {1'b0, width_r};
    last_row = ({1'b0, frow_r} + 17'd1) >= {1'b0, height_r};

    phase_nxt = phase_r;
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    offset_nxt = offset_r;
    width_nxt = width_r;
    height_nxt = height_r;
    col_nxt = col_r;
    frow_nxt = frow_r;
    tri_nxt = tri_r;
    blue_nxt = blue_r;
    green_nxt = green_r;
    pad_nxt = pad_r;
    push = 1'b0;
    push_cmd = '0;

    if (in_acc) begin
      phase_nxt = cur_phase;
      pos_nxt = cur_pos;
      acc_nxt = cur_acc;
      case (cur_phase)
        PH_HEADER, PH_HEADER_BAD: begin
          acc_nxt = acc_new;
          pos_nxt = pos_inc;
          if (cur_pos == 32'd1 && hi16 != BMP_MAGIC) begin
            phase_nxt = PH_HEADER_BAD;
          end else if (cur_pos == 32'd13) begin
            offset_nxt = acc_new;
          end else if (cur_pos == 32'd21) begin
            width_nxt = acc_new[15:0];
          end else if (cur_pos == 32'd25) begin
            height_nxt = acc_new[15:0];
          end else if (cur_pos == 32'd27 && hi16 != BMP_PLANES) begin
            phase_nxt = PH_HEADER_BAD;
          end else if (cur_pos == 32'd29 && hi16 != BMP_BPP) begin
            phase_nxt = PH_HEADER_BAD;
          end else if (cur_pos == 32'(HEADER_BYTES - 1)) begin
            push = 1'b1;
            if (cur_phase == PH_HEADER_BAD || acc_new != 32'd0) begin
              phase_nxt = PH_DONE;
              push_cmd.kind = KIND_REJECT;
            end else if (width_r == 16'd0 || height_r == 16'd0) begin
              phase_nxt = PH_DONE;
              push_cmd.kind = KIND_ACCEPT;
              push_cmd.last = 1'b1;
            end else begin
              frow_nxt = '0;
              col_nxt = '0;
              tri_nxt = '0;
              phase_nxt = (offset_r <= 32'(HEADER_BYTES)) ? PH_PIXEL : PH_SKIP;
              push_cmd.kind = KIND_ACCEPT;
            end
          end
        end
        PH_SKIP: begin
          pos_nxt = pos_inc;
          if (pos_inc >= offset_r) begin
            phase_nxt = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          if (tri_r == 2'd0) begin
            blue_nxt = b;
            tri_nxt = 2'd1;
          end else if (tri_r == 2'd1) begin
            green_nxt = b;
            tri_nxt = 2'd2;
          end else begin
            push = 1'b1;
            push_cmd.kind = KIND_PIXEL;
            push_cmd.blue = blue_r;
            push_cmd.green = green_r;
            push_cmd.red = b;
            push_cmd.column = col_r;
            push_cmd.file_row = frow_r;
            push_cmd.height = height_r;
            tri_nxt = 2'd0;
            if (last_col && last_row) begin
              phase_nxt = PH_DONE;
              push_cmd.last = 1'b1;
            end else if (last_col) begin
              frow_nxt = frow_r + 16'd1;
              col_nxt = '0;
              pad_nxt = width_r[1:0];
              if (width_r[1:0] != 2'd0) begin
                phase_nxt = PH_PAD;
              end
            end else begin
              col_nxt = col_r + 16'd1;
            end
          end
        end
        PH_PAD: begin
          pad_nxt = pad_r - 2'd1;
          if (pad_r == 2'd1) begin
            phase_nxt = PH_PIXEL;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r <= '0;
      acc_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r <= pos_nxt;
      acc_r <= acc_nxt;
    end
    offset_r <= offset_nxt;
    width_r <= width_nxt;
    height_r <= height_nxt;
    col_r <= col_nxt;
    frow_r <= frow_nxt;
    tri_r <= tri_nxt;
    blue_r <= blue_nxt;
    green_r <= green_nxt;
    pad_r <= pad_nxt;
  end

endmodule

@@ src/bmp565_queue.sv @@
// Short command queue between the parser and the pixel formatter.
module bmp565_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  bmp565_pkg::cmd_t      push_cmd,
  input  logic                  pop,
  output bmp565_pkg::cmd_t      head,
  output bmp565_pkg::q_status_t status
);
  import bmp565_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  always_comb begin
    status.full = (count_r == QCNT_W'(QDEPTH));
    status.empty = (count_r == '0);
    head = slot_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !status.full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("queue read while empty");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not follow a lone write");

endmodule

@@ src/bmp565_back.sv @@
// Back end: packs RGB565, computes the screen row and holds the result register.
module bmp565_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bmp565_pkg::cmd_t      head,
  input  bmp565_pkg::q_status_t q_status,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bmp565_pkg::out_item_t out_data
);
  import bmp565_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r, item_nxt;
  logic      is_pixel;

  always_comb begin
    pop = !q_status.empty && (!valid_r || !out_stall);
    is_pixel = (head.kind == KIND_PIXEL);
    item_nxt.result_kind = head.kind;
    item_nxt.pixel_color = is_pixel ?
        {head.red[7:3], head.green[7:2], head.blue[7:3]} : 16'd0;
    item_nxt.pixel_column = is_pixel ? head.column : 16'd0;
    item_nxt.pixel_row = is_pixel ? (head.height - 16'd1 - head.file_row) : 16'd0;
    item_nxt.last_pixel = head.last;
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (pop) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data = item_r;

  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> valid_r)
    else $error("result register not loaded after queue read");

  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_stall) |-> !pop)
    else $error("queue read while a stalled result is held");

endmodule
